>>> rtl/core/fcb_pkg.sv
// ----------------------------------------------------------------------------
// fcb_pkg
// Types, constants and rounding helpers shared by the camera basis unit.
// ----------------------------------------------------------------------------
`default_nettype none

package fcb_pkg;

    // block configuration
    localparam int ANGLE_BITS     = 16;
    localparam int PITCH_LIMIT    = 15341;
    localparam int UNIT_FRAC_BITS = 14;

    // field widths
    localparam int STEP_W  = 16;
    localparam int POS_W   = 32;
    localparam int FIELD_W = 16;

    // cordic datapath, Q2.30 values on a 2^32 per turn angle
    localparam int CW           = 32;
    localparam int CORDIC_STEPS = 30;
    localparam int ITER_W       = $clog2(CORDIC_STEPS);
    localparam logic signed [CW-1:0] CORDIC_GAIN  = 32'sh26DD3B6A;
    localparam logic signed [CW:0]   TURN_QUARTER = (CW+1)'(1) <<< (CW - 2);
    localparam logic signed [CW:0]   TURN_HALF    = (CW+1)'(1) <<< (CW - 1);

    // degrees in Q8.8 to binary angle: 360 * 256 per turn
    localparam int DEG_DIV   = 92160;
    localparam int DEG_HALF  = DEG_DIV / 2;
    localparam int DIV_STEPS = ANGLE_BITS - 1;
    localparam int NUM_W     = STEP_W + ANGLE_BITS;
    localparam int REM_W     = $clog2(DEG_DIV);

    localparam int PITCH_QMAX = (1 << (ANGLE_BITS - 2)) - 1;
    localparam int PITCH_LIM  = (PITCH_LIMIT > PITCH_QMAX) ? PITCH_QMAX : PITCH_LIMIT;
    localparam logic signed [ANGLE_BITS:0] PITCH_HI = (ANGLE_BITS+1)'(PITCH_LIM);
    localparam logic signed [ANGLE_BITS:0] PITCH_LO = -PITCH_HI;
    localparam logic [ANGLE_BITS-1:0] YAW_RESET = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

    // digit serial multiplier
    localparam int DIGIT_W    = 4;
    localparam int MUL_DIGITS = CW / DIGIT_W;
    localparam int PW         = 2 * CW;
    localparam int LANES      = 4;

    // sequencer counter covers the longest phase
    localparam int MAX_STEPS_A = (DIV_STEPS > CORDIC_STEPS) ? DIV_STEPS : CORDIC_STEPS;
    localparam int MAX_STEPS   = (MAX_STEPS_A > MUL_DIGITS) ? MAX_STEPS_A : MUL_DIGITS;
    localparam int CNT_W       = $clog2(MAX_STEPS);

    // rounding to Q1.F
    localparam int UW = UNIT_FRAC_BITS + 2;
    localparam int S1 = CW - 2 - UNIT_FRAC_BITS;
    localparam int S2 = PW - 4 - UNIT_FRAC_BITS;
    localparam logic signed [CW:0] SINGLE_HALF =
        (S1 > 0) ? ((CW+1)'(1) <<< ((S1 > 0) ? S1 - 1 : 0)) : (CW+1)'(0);
    localparam logic signed [PW:0] PROD_HALF = (PW+1)'(1) <<< (S2 - 1);

    // unit value to Q16.16
    localparam int LP_SHL = (UNIT_FRAC_BITS <= 16) ? 16 - UNIT_FRAC_BITS : 0;
    localparam int LP_SHR = (UNIT_FRAC_BITS > 16) ? UNIT_FRAC_BITS - 16 : 0;
    localparam longint LP_HALF =
        (LP_SHR > 0) ? (longint'(1) << ((LP_SHR > 0) ? LP_SHR - 1 : 0)) : longint'(0);

    typedef enum logic [1:0] {
        KIND_ROTATE = 2'd0,
        KIND_MOVE   = 2'd1,
        KIND_SET    = 2'd2
    } evt_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_APPLY,
        ST_LOAD,
        ST_CORDIC,
        ST_MUL,
        ST_ROUND,
        ST_DONE
    } fcb_state_t;

    typedef struct packed {
        logic              load;
        logic              step;
        logic [ITER_W-1:0] iter;
    } cordic_ctl_t;

    typedef struct packed {
        logic        [1:0]        kind;
        logic signed [STEP_W-1:0] yaw_step_deg;
        logic signed [STEP_W-1:0] pitch_step_deg;
        logic signed [POS_W-1:0]  vec_x;
        logic signed [POS_W-1:0]  vec_y;
        logic signed [POS_W-1:0]  vec_z;
    } evt_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] look_x;
        logic signed [FIELD_W-1:0] look_y;
        logic signed [FIELD_W-1:0] look_z;
        logic signed [FIELD_W-1:0] right_x;
        logic signed [FIELD_W-1:0] right_y;
        logic signed [FIELD_W-1:0] right_z;
        logic signed [FIELD_W-1:0] up_x;
        logic signed [FIELD_W-1:0] up_y;
        logic signed [FIELD_W-1:0] up_z;
        logic signed [POS_W-1:0]   target_x;
        logic signed [POS_W-1:0]   target_y;
        logic signed [POS_W-1:0]   target_z;
    } basis_t;

    // arctangent of 2^-i in 2^32 per turn units
    function automatic logic signed [CW-1:0] atan_step(input logic [ITER_W-1:0] i);
        logic signed [CW-1:0] a;
        case (i)
            0:       a = 32'sd536870912;
            1:       a = 32'sd316933406;
            2:       a = 32'sd167458907;
            3:       a = 32'sd85004756;
            4:       a = 32'sd42667331;
            5:       a = 32'sd21354465;
            6:       a = 32'sd10679838;
            7:       a = 32'sd5340245;
            8:       a = 32'sd2670163;
            9:       a = 32'sd1335087;
            10:      a = 32'sd667544;
            11:      a = 32'sd333772;
            12:      a = 32'sd166886;
            13:      a = 32'sd83443;
            14:      a = 32'sd41722;
            15:      a = 32'sd20861;
            16:      a = 32'sd10430;
            17:      a = 32'sd5215;
            18:      a = 32'sd2608;
            19:      a = 32'sd1304;
            20:      a = 32'sd652;
            21:      a = 32'sd326;
            22:      a = 32'sd163;
            23:      a = 32'sd81;
            24:      a = 32'sd41;
            25:      a = 32'sd20;
            26:      a = 32'sd10;
            27:      a = 32'sd5;
            28:      a = 32'sd3;
            29:      a = 32'sd1;
            default: a = 32'sd0;
        endcase
        return a;
    endfunction

    function automatic logic signed [UW-1:0] unit_limit(input logic signed [PW:0] v);
        logic signed [PW:0] hi;
        logic signed [PW:0] lo;
        hi = (PW+1)'(1) <<< UNIT_FRAC_BITS;
        lo = -hi;
        if (v > hi) begin
            return UW'(hi);
        end
        if (v < lo) begin
            return UW'(lo);
        end
        return UW'(v);
    endfunction

    // Q2.30 term to Q1.F, round half up
    function automatic logic signed [UW-1:0] round_single(input logic signed [CW-1:0] v);
        logic signed [CW:0] t;
        logic signed [PW:0] r;
        t = (CW+1)'(v) + SINGLE_HALF;
        t = t >>> S1;
        r = (PW+1)'(t);
        return unit_limit(r);
    endfunction

    // Q4.60 product to Q1.F, round half up
    function automatic logic signed [UW-1:0] round_prod(input logic signed [PW-1:0] p);
        logic signed [PW:0] t;
        t = (PW+1)'(p) + PROD_HALF;
        t = t >>> S2;
        return unit_limit(t);
    endfunction

    function automatic logic signed [FIELD_W-1:0] to_field(input logic signed [UW-1:0] u);
        logic signed [63:0] w;
        w = 64'(u);
        return FIELD_W'(w);
    endfunction

    function automatic logic signed [POS_W:0] look_to_pos(input logic signed [UW-1:0] u);
        logic signed [63:0] w;
        w = 64'(u);
        w = (w + 64'(LP_HALF)) >>> LP_SHR;
        w = w <<< LP_SHL;
        return (POS_W+1)'(w);
    endfunction

    function automatic logic signed [POS_W-1:0] sat_add(input logic signed [POS_W-1:0] a,
                                                         input logic signed [POS_W:0]   b);
        logic signed [POS_W+1:0] s;
        logic signed [POS_W+1:0] hi;
        logic signed [POS_W+1:0] lo;
        s  = (POS_W+2)'(a) + (POS_W+2)'(b);
        lo = -((POS_W+2)'(1) <<< (POS_W - 1));
        hi = ((POS_W+2)'(1) <<< (POS_W - 1)) - (POS_W+2)'(1);
        if (s > hi) begin
            return POS_W'(hi);
        end
        if (s < lo) begin
            return POS_W'(lo);
        end
        return POS_W'(s);
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/fcb_cordic.sv
// ----------------------------------------------------------------------------
// fcb_cordic
// Iterative rotation-mode cordic, one micro-rotation per step, cos and sin
// of a binary angle in Q2.30.
// ----------------------------------------------------------------------------
`default_nettype none

module fcb_cordic
    import fcb_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  cordic_ctl_t                 ctl,
    input  logic        [ANGLE_BITS-1:0] angle,
    output logic signed [CW-1:0]        cos_val,
    output logic signed [CW-1:0]        sin_val
);

    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] x_next;
    logic signed [CW-1:0] y_reg;
    logic signed [CW-1:0] y_next;
    logic signed [CW-1:0] z_reg;
    logic signed [CW-1:0] z_next;
    logic                 neg_reg;
    logic                 neg_next;

    logic signed [CW:0]   z_wide;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] atan_val;

    always_comb
    begin
        x_next   = x_reg;
        y_next   = y_reg;
        z_next   = z_reg;
        neg_next = neg_reg;
        z_wide   = (CW+1)'(signed'({angle, {(CW - ANGLE_BITS){1'b0}}}));
        dx       = y_reg >>> ctl.iter;
        dy       = x_reg >>> ctl.iter;
        atan_val = atan_step(ctl.iter);

        if (ctl.load)
        begin
            // fold angles beyond a quarter turn by a half turn
            neg_next = 1'b0;
            if (z_wide > TURN_QUARTER)
            begin
                z_wide   = z_wide - TURN_HALF;
                neg_next = 1'b1;
            end
            else if (z_wide < -TURN_QUARTER)
            begin
                z_wide   = z_wide + TURN_HALF;
                neg_next = 1'b1;
            end
            x_next = CORDIC_GAIN;
            y_next = '0;
            z_next = CW'(z_wide);
        end
        else if (ctl.step)
        begin
            if (!z_reg[CW-1])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - atan_val;
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + atan_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neg_reg <= 1'b0;
        end
        else
        begin
            neg_reg <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign cos_val = neg_reg ? -x_reg : x_reg;
    assign sin_val = neg_reg ? -y_reg : y_reg;

endmodule

`default_nettype wire

>>> rtl/core/fps_camera_basis_update.sv
// ----------------------------------------------------------------------------
// fps_camera_basis_update
// First-person camera: keeps yaw, pitch and position, and answers every
// request with the look, right and up vectors and the target point.
// ----------------------------------------------------------------------------
// Usage:
//   evt channel (evt_valid/evt_ready/evt) takes one request: rotate by degree
//   steps, move by a vector, or set the position. basis channel
//   (basis_valid/basis_ready/basis) returns one result per request.
//   A rotate request first runs the bit-serial degree conversion (one
//   quotient bit per cycle) and the angle update; every request then runs
//   the cordic, the multiplier and the rounding, and its result is loaded
//   into the output register. Requests are accepted only in the idle
//   state, so the block takes no new request before the last result is
//   loaded. The main phases are the 30-step cordic (one micro-rotation
//   per cycle, yaw and pitch side by side) and the radix-16 multiplier
//   (8 digits). A result waiting in the output register does not block
//   the next request; if it is still not taken when the next result is
//   ready, the sequencer holds until basis_ready.
//   Reset: yaw is a half turn, pitch and position are zero, no result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module fps_camera_basis_update
    import fcb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   evt_valid,
    output logic   evt_ready,
    input  evt_t   evt,
    output logic   basis_valid,
    input  logic   basis_ready,
    output basis_t basis
);

    fcb_state_t state_reg;
    fcb_state_t state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    logic        [ANGLE_BITS-1:0] yaw_reg;
    logic        [ANGLE_BITS-1:0] yaw_next;
    logic signed [ANGLE_BITS-1:0] pitch_reg;
    logic signed [ANGLE_BITS-1:0] pitch_next;
    logic signed [POS_W-1:0]      pos_x_reg;
    logic signed [POS_W-1:0]      pos_x_next;
    logic signed [POS_W-1:0]      pos_y_reg;
    logic signed [POS_W-1:0]      pos_y_next;
    logic signed [POS_W-1:0]      pos_z_reg;
    logic signed [POS_W-1:0]      pos_z_next;

    // degree conversion, one quotient bit per cycle
    logic                 yaw_neg_reg;
    logic                 pitch_neg_reg;
    logic [REM_W-1:0]     yrem_reg;
    logic [REM_W-1:0]     yrem_next;
    logic [REM_W-1:0]     prem_reg;
    logic [REM_W-1:0]     prem_next;
    logic [DIV_STEPS-1:0] ynum_reg;
    logic [DIV_STEPS-1:0] ynum_next;
    logic [DIV_STEPS-1:0] pnum_reg;
    logic [DIV_STEPS-1:0] pnum_next;
    logic [STEP_W-1:0]    yaw_mag;
    logic [STEP_W-1:0]    pitch_mag;
    logic [NUM_W-1:0]     ynum_init;
    logic [NUM_W-1:0]     pnum_init;
    logic [REM_W:0]       ytrial;
    logic [REM_W:0]       ptrial;
    logic                 yge;
    logic                 pge;

    logic signed [ANGLE_BITS:0] pitch_delta;
    logic signed [ANGLE_BITS:0] pitch_sum;

    // sine and cosine
    cordic_ctl_t          cordic_ctl;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] cp;
    logic signed [CW-1:0] sp;

    // product lanes
    logic signed [CW-1:0]      mul_a    [LANES];
    logic signed [CW-1:0]      mul_b    [LANES];
    logic signed [CW-1:0]      b_cur    [LANES];
    logic        [DIGIT_W:0]   digit    [LANES];
    logic signed [CW+DIGIT_W:0] partial [LANES];
    logic signed [CW-1:0]      msh_reg  [LANES];
    logic signed [CW-1:0]      msh_next [LANES];
    logic signed [PW-1:0]      acc_reg  [LANES];
    logic signed [PW-1:0]      acc_next [LANES];
    logic                      first_digit;

    logic signed [UW-1:0] look_x_reg;
    logic signed [UW-1:0] look_y_reg;
    logic signed [UW-1:0] look_z_reg;
    logic signed [UW-1:0] right_x_reg;
    logic signed [UW-1:0] right_z_reg;
    logic signed [UW-1:0] up_x_reg;
    logic signed [UW-1:0] up_y_reg;
    logic signed [UW-1:0] up_z_reg;

    basis_t basis_reg;
    basis_t basis_next;
    logic   basis_valid_reg;
    logic   basis_valid_next;
    logic   out_load;
    logic   evt_take;

    // ------------------------------------------------------------------ fsm

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (evt_valid)
                begin
                    state_next = (evt.kind == KIND_ROTATE) ? ST_DIV : ST_LOAD;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:  state_next = ST_LOAD;
            ST_LOAD:   state_next = ST_CORDIC;
            ST_CORDIC:
            begin
                if (cnt_reg == CNT_W'(CORDIC_STEPS - 1))
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (cnt_reg == CNT_W'(MUL_DIGITS - 1))
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (!basis_valid_reg || basis_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
        cnt_next = (state_next != state_reg) ? '0 : cnt_reg + CNT_W'(1);
    end

    always_comb
    begin
        evt_ready       = 1'b0;
        cordic_ctl.load = 1'b0;
        cordic_ctl.step = 1'b0;
        cordic_ctl.iter = cnt_reg[ITER_W-1:0];
        out_load        = 1'b0;
        unique case (state_reg)
            ST_IDLE:   evt_ready = 1'b1;
            ST_LOAD:   cordic_ctl.load = 1'b1;
            ST_CORDIC: cordic_ctl.step = 1'b1;
            ST_DONE:   out_load = !basis_valid_reg || basis_ready;
            default:
            begin
                evt_ready = 1'b0;
            end
        endcase
    end

    assign evt_take = evt_valid && evt_ready;

    // ------------------------------------------------------- angle update

    always_comb
    begin
        yaw_mag   = evt.yaw_step_deg[STEP_W-1] ? STEP_W'(-evt.yaw_step_deg)
                                               : evt.yaw_step_deg;
        pitch_mag = evt.pitch_step_deg[STEP_W-1] ? STEP_W'(-evt.pitch_step_deg)
                                                 : evt.pitch_step_deg;
        ynum_init = (NUM_W'(yaw_mag) << ANGLE_BITS) + NUM_W'(DEG_HALF);
        pnum_init = (NUM_W'(pitch_mag) << ANGLE_BITS) + NUM_W'(DEG_HALF);

        // restoring divide by the degree constant
        ytrial    = {yrem_reg, ynum_reg[DIV_STEPS-1]};
        ptrial    = {prem_reg, pnum_reg[DIV_STEPS-1]};
        yge       = ytrial >= (REM_W+1)'(DEG_DIV);
        pge       = ptrial >= (REM_W+1)'(DEG_DIV);
        yrem_next = REM_W'(yge ? ytrial - (REM_W+1)'(DEG_DIV) : ytrial);
        prem_next = REM_W'(pge ? ptrial - (REM_W+1)'(DEG_DIV) : ptrial);
        ynum_next = {ynum_reg[DIV_STEPS-2:0], yge};
        pnum_next = {pnum_reg[DIV_STEPS-2:0], pge};

        pitch_delta = signed'((ANGLE_BITS+1)'(pnum_reg));
        if (pitch_neg_reg)
        begin
            pitch_delta = -pitch_delta;
        end
        pitch_sum = (ANGLE_BITS+1)'(pitch_reg) + pitch_delta;

        yaw_next   = yaw_reg;
        pitch_next = pitch_reg;
        if (state_reg == ST_APPLY)
        begin
            yaw_next = yaw_reg + (yaw_neg_reg ? ANGLE_BITS'(0) - ANGLE_BITS'(ynum_reg)
                                              : ANGLE_BITS'(ynum_reg));
            if (pitch_sum > PITCH_HI)
            begin
                pitch_next = ANGLE_BITS'(PITCH_HI);
            end
            else if (pitch_sum < PITCH_LO)
            begin
                pitch_next = ANGLE_BITS'(PITCH_LO);
            end
            else
            begin
                pitch_next = ANGLE_BITS'(pitch_sum);
            end
        end
    end

    // ----------------------------------------------------- position update

    always_comb
    begin
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        pos_z_next = pos_z_reg;
        if (evt_take)
        begin
            unique case (evt.kind)
                KIND_MOVE:
                begin
                    pos_x_next = sat_add(pos_x_reg, (POS_W+1)'(evt.vec_x));
                    pos_y_next = sat_add(pos_y_reg, (POS_W+1)'(evt.vec_y));
                    pos_z_next = sat_add(pos_z_reg, (POS_W+1)'(evt.vec_z));
                end
                KIND_SET:
                begin
                    pos_x_next = evt.vec_x;
                    pos_y_next = evt.vec_y;
                    pos_z_next = evt.vec_z;
                end
                default:
                begin
                    pos_x_next = pos_x_reg;
                end
            endcase
        end
    end

    // --------------------------------------------------------- sin and cos

    fcb_cordic u_cordic_yaw (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (cordic_ctl),
        .angle   (yaw_reg),
        .cos_val (cy),
        .sin_val (sy)
    );

    fcb_cordic u_cordic_pitch (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (cordic_ctl),
        .angle   (pitch_reg),
        .cos_val (cp),
        .sin_val (sp)
    );

    // ------------------------------------------- radix-16 serial multiplier

    always_comb
    begin
        mul_a[0] = cp;
        mul_b[0] = sy;
        mul_a[1] = cp;
        mul_b[1] = cy;
        mul_a[2] = sy;
        mul_b[2] = sp;
        mul_a[3] = cy;
        mul_b[3] = sp;
        first_digit = (cnt_reg == '0);
        for (int k = 0; k < LANES; k++)
        begin
            // msb digit first; the top digit carries the sign
            b_cur[k]    = first_digit ? mul_b[k] : msh_reg[k];
            digit[k]    = {first_digit ? b_cur[k][CW-1] : 1'b0, b_cur[k][CW-1 -: DIGIT_W]};
            msh_next[k] = b_cur[k] <<< DIGIT_W;
            partial[k]  = mul_a[k] * signed'(digit[k]);
            acc_next[k] = (first_digit ? PW'(0) : (acc_reg[k] <<< DIGIT_W)) + PW'(partial[k]);
        end
    end

    // ------------------------------------------------------------- result

    always_comb
    begin
        basis_next.look_x   = to_field(look_x_reg);
        basis_next.look_y   = to_field(look_y_reg);
        basis_next.look_z   = to_field(look_z_reg);
        basis_next.right_x  = to_field(right_x_reg);
        basis_next.right_y  = '0;
        basis_next.right_z  = to_field(right_z_reg);
        basis_next.up_x     = to_field(up_x_reg);
        basis_next.up_y     = to_field(up_y_reg);
        basis_next.up_z     = to_field(up_z_reg);
        basis_next.target_x = sat_add(pos_x_reg, look_to_pos(look_x_reg));
        basis_next.target_y = sat_add(pos_y_reg, look_to_pos(look_y_reg));
        basis_next.target_z = sat_add(pos_z_reg, look_to_pos(look_z_reg));

        basis_valid_next = basis_valid_reg;
        if (out_load)
        begin
            basis_valid_next = 1'b1;
        end
        else if (basis_ready)
        begin
            basis_valid_next = 1'b0;
        end
    end

    // ----------------------------------------------------------- registers

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            yaw_reg         <= YAW_RESET;
            pitch_reg       <= '0;
            pos_x_reg       <= '0;
            pos_y_reg       <= '0;
            pos_z_reg       <= '0;
            basis_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            yaw_reg         <= yaw_next;
            pitch_reg       <= pitch_next;
            pos_x_reg       <= pos_x_next;
            pos_y_reg       <= pos_y_next;
            pos_z_reg       <= pos_z_next;
            basis_valid_reg <= basis_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_take)
        begin
            yaw_neg_reg   <= evt.yaw_step_deg[STEP_W-1];
            pitch_neg_reg <= evt.pitch_step_deg[STEP_W-1];
            yrem_reg      <= REM_W'(ynum_init >> DIV_STEPS);
            prem_reg      <= REM_W'(pnum_init >> DIV_STEPS);
            ynum_reg      <= ynum_init[DIV_STEPS-1:0];
            pnum_reg      <= pnum_init[DIV_STEPS-1:0];
        end
        else if (state_reg == ST_DIV)
        begin
            yrem_reg <= yrem_next;
            prem_reg <= prem_next;
            ynum_reg <= ynum_next;
            pnum_reg <= pnum_next;
        end

        if (state_reg == ST_MUL)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                msh_reg[k] <= msh_next[k];
                acc_reg[k] <= acc_next[k];
            end
        end

        if (state_reg == ST_ROUND)
        begin
            look_x_reg  <= round_prod(acc_reg[0]);
            look_y_reg  <= round_single(sp);
            look_z_reg  <= round_prod(-acc_reg[1]);
            right_x_reg <= round_single(cy);
            right_z_reg <= round_single(sy);
            up_x_reg    <= round_prod(-acc_reg[2]);
            up_y_reg    <= round_single(cp);
            up_z_reg    <= round_prod(acc_reg[3]);
        end

        if (out_load)
        begin
            basis_reg <= basis_next;
        end
    end

    assign basis       = basis_reg;
    assign basis_valid = basis_valid_reg;

endmodule

`default_nettype wire

>>> tb/tb_fps_camera_basis_update.sv
// ----------------------------------------------------------------------------
// tb_fps_camera_basis_update
// Self-checking bench for the camera basis unit: a queue-fed driver sends
// rotate, move, set and unused-kind requests, a bit-exact basis predictor
// computes each result, and a monitor compares every returned basis field
// by field while both handshakes idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_fps_camera_basis_update;
    import fcb_pkg::*;

    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         RANDOM_ITEMS   = 1080;
    localparam int         DRAIN_LATENCY  = 64;
    localparam int         QUIET_FIRST    = 400;
    localparam int         QUIET_LAST     = 600;
    localparam logic [1:0] KIND_UNUSED    = 2'd3;
    localparam longint     PITCH_CLAMP    = 15341;
    localparam longint     CORDIC_START   = 652032874;
    localparam longint     UNIT_ONE       = 16384;

    logic   clk         = 1'b0;
    logic   rst_n       = 1'b0;
    logic   evt_valid   = 1'b0;
    logic   evt_ready;
    evt_t   evt         = '0;
    logic   basis_valid;
    logic   basis_ready = 1'b0;
    basis_t basis;

    fps_camera_basis_update u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .evt_valid   (evt_valid),
        .evt_ready   (evt_ready),
        .evt         (evt),
        .basis_valid (basis_valid),
        .basis_ready (basis_ready),
        .basis       (basis)
    );

    always #4 clk = ~clk;

    // camera state as the predictor sees it
    logic [15:0] cam_yaw   = 16'h8000;
    longint      cam_pitch = 0;
    longint      cam_pos_x = 0;
    longint      cam_pos_y = 0;
    longint      cam_pos_z = 0;

    longint atan_turns [30] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1
    };

    string basis_field_names [12] = '{
        "look_x", "look_y", "look_z", "right_x", "right_y", "right_z",
        "up_x", "up_y", "up_z", "target_x", "target_y", "target_z"
    };

    evt_t   evt_pending    [$];
    basis_t basis_expected [$];
    basis_t want_basis;

    int  send_gap      = 0;
    int  recv_gap      = 0;
    int  accepted_cnt  = 0;
    int  results_seen  = 0;
    int  mismatches    = 0;
    int  idle_cycles   = 0;
    bit  timed_out     = 1'b0;
    int  kind_count [4] = '{default: 0};

    // ------------------------------------------------------------------
    // basis predictor
    // ------------------------------------------------------------------
    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint unit_clamp(input longint v);
        if (v > UNIT_ONE)
        begin
            return UNIT_ONE;
        end
        if (v < -UNIT_ONE)
        begin
            return -UNIT_ONE;
        end
        return v;
    endfunction

    // Q2.30 to Q1.14, half up
    function automatic longint single_to_unit(input longint v);
        return unit_clamp((v + (longint'(1) <<< 15)) >>> 16);
    endfunction

    // Q4.60 to Q1.14, half up
    function automatic longint product_to_unit(input longint p);
        return unit_clamp((p + (longint'(1) <<< 45)) >>> 46);
    endfunction

    // Q8.8 degrees to 2^16 per turn, nearest, ties away from zero
    function automatic longint degrees_to_angle(input logic signed [15:0] raw);
        longint d;
        longint mag;
        longint q;
        d   = raw;
        mag = (d < 0 ? -d : d) * 65536;
        q   = (mag + 46080) / 92160;
        return (d < 0) ? -q : q;
    endfunction

    function automatic void cordic_sincos(input logic [15:0] ang,
                                          output longint c, output longint s);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        bit     flip;
        x    = CORDIC_START;
        y    = 0;
        flip = 1'b0;
        z    = longint'({ang, 16'h0000});
        if (z >= (longint'(1) <<< 31))
        begin
            z = z - (longint'(1) <<< 32);
        end
        // fold the back half of the circle onto the front half
        if (z > (longint'(1) <<< 30))
        begin
            z    = z - (longint'(1) <<< 31);
            flip = 1'b1;
        end
        else if (z < -(longint'(1) <<< 30))
        begin
            z    = z + (longint'(1) <<< 31);
            flip = 1'b1;
        end
        for (int i = 0; i < 30; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - atan_turns[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + atan_turns[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic basis_t camera_basis_predict(input evt_t e);
        basis_t r;
        longint cy;
        longint sy;
        longint cp;
        longint sp;
        longint lx;
        longint ly;
        longint lz;
        longint p;
        case (e.kind)
            KIND_ROTATE:
            begin
                cam_yaw = cam_yaw + 16'(degrees_to_angle(e.yaw_step_deg));
                p = cam_pitch + degrees_to_angle(e.pitch_step_deg);
                if (p > PITCH_CLAMP)
                begin
                    p = PITCH_CLAMP;
                end
                else if (p < -PITCH_CLAMP)
                begin
                    p = -PITCH_CLAMP;
                end
                cam_pitch = p;
            end
            KIND_MOVE:
            begin
                cam_pos_x = sat32(cam_pos_x + longint'(e.vec_x));
                cam_pos_y = sat32(cam_pos_y + longint'(e.vec_y));
                cam_pos_z = sat32(cam_pos_z + longint'(e.vec_z));
            end
            KIND_SET:
            begin
                cam_pos_x = e.vec_x;
                cam_pos_y = e.vec_y;
                cam_pos_z = e.vec_z;
            end
            default:
            begin
            end
        endcase

        cordic_sincos(cam_yaw, cy, sy);
        cordic_sincos(16'(cam_pitch), cp, sp);
        lx = product_to_unit(cp * sy);
        ly = single_to_unit(sp);
        lz = product_to_unit(-(cp * cy));

        r.look_x   = 16'(lx);
        r.look_y   = 16'(ly);
        r.look_z   = 16'(lz);
        r.right_x  = 16'(single_to_unit(cy));
        r.right_y  = '0;
        r.right_z  = 16'(single_to_unit(sy));
        r.up_x     = 16'(product_to_unit(-(sy * sp)));
        r.up_y     = 16'(single_to_unit(cp));
        r.up_z     = 16'(product_to_unit(cy * sp));
        // Q1.14 look to Q16.16 is a plain shift by two
        r.target_x = 32'(sat32(cam_pos_x + lx * 4));
        r.target_y = 32'(sat32(cam_pos_y + ly * 4));
        r.target_z = 32'(sat32(cam_pos_z + lz * 4));
        return r;
    endfunction

    function automatic longint basis_field(input basis_t b, input int idx);
        case (idx)
            0:       return b.look_x;
            1:       return b.look_y;
            2:       return b.look_z;
            3:       return b.right_x;
            4:       return b.right_y;
            5:       return b.right_z;
            6:       return b.up_x;
            7:       return b.up_y;
            8:       return b.up_z;
            9:       return b.target_x;
            10:      return b.target_y;
            default: return b.target_z;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic evt_t make_evt(input logic [1:0] kind, input logic [15:0] yaw,
                                      input logic [15:0] pitch, input logic [31:0] x,
                                      input logic [31:0] y, input logic [31:0] z);
        evt_t e;
        e.kind           = kind;
        e.yaw_step_deg   = yaw;
        e.pitch_step_deg = pitch;
        e.vec_x          = x;
        e.vec_y          = y;
        e.vec_z          = z;
        return e;
    endfunction

    // random word spread over +-2^(span_bits-1)
    function automatic logic [31:0] random_coord(input int span_bits);
        return $signed($urandom) >>> (32 - span_bits);
    endfunction

    function automatic logic [31:0] edge_coord();
        if ($urandom_range(1) == 1)
        begin
            return 32'h7fff_ffff - $urandom_range(0, 65536);
        end
        return 32'h8000_0000 + $urandom_range(0, 65536);
    endfunction

    function automatic evt_t random_evt();
        evt_t        e;
        int unsigned pick;
        int unsigned style;
        int          span;
        pick  = $urandom_range(99);
        style = $urandom_range(3);
        e     = make_evt(2'($urandom), 16'($urandom), 16'($urandom), $urandom, $urandom,
                         $urandom);
        if (pick < 40)
        begin
            e.kind = KIND_ROTATE;
            if (style != 0)
            begin
                // mostly a few degrees, so pitch wanders between the stops
                e.yaw_step_deg   = $signed(e.yaw_step_deg) >>> $urandom_range(1, 7);
                e.pitch_step_deg = $signed(e.pitch_step_deg) >>> $urandom_range(2, 8);
            end
        end
        else if (pick < 70)
        begin
            e.kind = KIND_MOVE;
            span   = (style == 0) ? 32 : 21;
            e.vec_x = random_coord(span);
            e.vec_y = random_coord(span);
            e.vec_z = random_coord(span);
        end
        else if (pick < 90)
        begin
            e.kind = KIND_SET;
            if (style == 1)
            begin
                e.vec_x = edge_coord();
                e.vec_y = edge_coord();
                e.vec_z = edge_coord();
            end
            else if (style != 0)
            begin
                e.vec_x = random_coord(25);
                e.vec_y = random_coord(25);
                e.vec_z = random_coord(25);
            end
        end
        else
        begin
            e.kind = KIND_UNUSED;
        end
        return e;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(99) < 80)
        begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(20, 120);
    endfunction

    // ------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            evt_valid <= 1'b0;
        end
        else
        begin
            if (evt_valid && evt_ready)
            begin
                basis_expected.push_back(camera_basis_predict(evt));
                kind_count[evt.kind] = kind_count[evt.kind] + 1;
                accepted_cnt = accepted_cnt + 1;
            end
            if (!evt_valid || evt_ready)
            begin
                if (evt_pending.size() != 0 && send_gap == 0)
                begin
                    evt       <= evt_pending.pop_front();
                    evt_valid <= 1'b1;
                end
                else
                begin
                    evt_valid <= 1'b0;
                end
            end
            if (send_gap > 0)
            begin
                send_gap = send_gap - 1;
            end
            else if ((accepted_cnt < QUIET_FIRST || accepted_cnt >= QUIET_LAST)
                     && $urandom_range(99) < 2)
            begin
                send_gap = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            basis_ready <= 1'b0;
        end
        else
        begin
            if (basis_valid && basis_ready)
            begin
                results_seen = results_seen + 1;
                if (basis_expected.size() == 0)
                begin
                    $display("%0t: basis result with no request pending, expected none, got %h",
                             $time, basis);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want_basis = basis_expected.pop_front();
                    for (int k = 0; k < 12; k++)
                    begin
                        if (basis_field(basis, k) != basis_field(want_basis, k))
                        begin
                            $display("%0t: %s mismatch, expected %0d, got %0d", $time,
                                     basis_field_names[k], basis_field(want_basis, k),
                                     basis_field(basis, k));
                            mismatches = mismatches + 1;
                        end
                    end
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap = recv_gap - 1;
            end
            else if ((results_seen < QUIET_FIRST || results_seen >= QUIET_LAST)
                     && $urandom_range(99) < 2)
            begin
                recv_gap = pick_gap();
            end
            basis_ready <= (recv_gap == 0);
        end
    end

    // cycles without any handshake
    always @(posedge clk)
    begin
        if (!rst_n || (evt_valid && evt_ready) || (basis_valid && basis_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                timed_out <= 1'b1;
            end
        end
    end

    task automatic wait_drained();
        while ((evt_pending.size() != 0 || evt_valid || basis_expected.size() != 0)
               && !timed_out)
        begin
            @(negedge clk);
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        // unused kind with all ones must leave the reset state alone
        evt_pending.push_back(make_evt(KIND_UNUSED, 16'hffff, 16'hffff,
                                       32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
        evt_pending.push_back(make_evt(KIND_ROTATE, 16'd23040, 16'd0, 0, 0, 0));
        evt_pending.push_back(make_evt(KIND_ROTATE, 16'h7fff, 16'h7fff, 0, 0, 0));
        evt_pending.push_back(make_evt(KIND_ROTATE, 16'h8000, 16'h8000, 0, 0, 0));
        evt_pending.push_back(make_evt(KIND_ROTATE, 16'h8000, 16'h8000, 0, 0, 0));
        evt_pending.push_back(make_evt(KIND_ROTATE, 16'd46080, 16'd23040, 0, 0, 0));
        evt_pending.push_back(make_evt(KIND_SET, 16'd0, 16'd0, 32'h7fff_ffff, 32'h7fff_ffff,
                                       32'h7fff_ffff));
        evt_pending.push_back(make_evt(KIND_MOVE, 16'd0, 16'd0, 32'h7fff_ffff, 32'h7fff_ffff,
                                       32'h7fff_ffff));
        evt_pending.push_back(make_evt(KIND_ROTATE, 16'hffff, 16'h8000, 0, 0, 0));
        evt_pending.push_back(make_evt(KIND_SET, 16'd0, 16'd0, 32'h8000_0000, 32'h8000_0000,
                                       32'h8000_0000));
        evt_pending.push_back(make_evt(KIND_MOVE, 16'd0, 16'd0, 32'h8000_0000, 32'h8000_0000,
                                       32'h8000_0000));
        evt_pending.push_back(make_evt(KIND_ROTATE, 16'd23040, 16'h7fff, 0, 0, 0));
        evt_pending.push_back(make_evt(KIND_MOVE, 16'd0, 16'd0, 32'h7fff_ffff, 32'h7fff_ffff,
                                       32'h7fff_ffff));
        evt_pending.push_back(make_evt(KIND_SET, 16'd0, 16'd0, 32'h5555_5555, 32'haaaa_aaaa,
                                       32'h0000_0000));
        evt_pending.push_back(make_evt(KIND_MOVE, 16'd0, 16'd0, 32'hffff_ffff, 32'h0001_0000,
                                       32'hfffe_8000));
        evt_pending.push_back(make_evt(KIND_ROTATE, 16'hffff - 16'd23039, 16'd0, 0, 0, 0));
        evt_pending.push_back(make_evt(KIND_ROTATE, 16'h5555, 16'haaaa, 0, 0, 0));
        evt_pending.push_back(make_evt(KIND_ROTATE, 16'd0, 16'd0, 0, 0, 0));
        evt_pending.push_back(make_evt(KIND_SET, 16'd0, 16'd0, 0, 0, 0));
        evt_pending.push_back(make_evt(KIND_UNUSED, 16'h0000, 16'h0000, 0, 0, 0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // sender holds off until the directed results are all back
        wait_drained();
        for (int n = 0; n < RANDOM_ITEMS / 2; n++)
        begin
            evt_pending.push_back(random_evt());
        end
        wait_drained();
        for (int n = RANDOM_ITEMS / 2; n < RANDOM_ITEMS; n++)
        begin
            evt_pending.push_back(random_evt());
        end
        wait_drained();
        repeat (DRAIN_LATENCY) @(negedge clk);

        if (timed_out)
        begin
            $display("simulation failed");
        end
        else
        begin
            $display("requests: %0d rotate, %0d move, %0d set, %0d unused kind",
                     kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
            $display("basis results checked: %0d, field mismatches: %0d",
                     results_seen, mismatches);
            if (mismatches == 0)
            begin
                $display("simulation ok");
            end
            else
            begin
                $display("simulation failed");
            end
        end
        $finish;
    end

endmodule

`default_nettype wire
